// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is asserted.
`define QBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define QBS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ===== design/qbs_pkg.sv =====
package qbs_pkg;

    localparam int DEPTH     = 64;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = IDX_W + 1;
    localparam int STACK_MAX = DEPTH / 2;
    localparam int VAL_W     = 32;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] value_res;
        logic                    last_res;
        logic                    truncated;
    } t_out_item;

endpackage

// ===== design/quicksort_buffer_sorter_unit.sv =====
// Channel   Direction  Handshake                    Payload
// -------   ---------  ---------------------------  ---------------------------------
// input     in         start high while busy low    i_item   (value, last)
// result    out        o_strobe, one cycle, no hold o_result (value_res, last_res,
//                                                             truncated)
//
// Flow: loading takes one item per cycle. After the item marked last, the
//   sort runs with busy high: one element per cycle compared in a partition
//   scan, then the swaps, and per partition a pivot read, final pivot swap,
//   range stack push and pop. The single read port of the element store
//   sets this pace. Results then stream one per cycle.
// Reset: synchronous, active low; clears the fill count, overflow flag, stack
//   pointer, sequencer and strobe. The memories need no clearing pass.
// Stalls: none on the result side; the receiver takes every strobed item.
`include "assert_macros.svh"

module quicksort_buffer_sorter_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  qbs_pkg::t_in_item   i_item,
    output logic                o_strobe,
    output qbs_pkg::t_out_item  o_result
);

    localparam int IW = qbs_pkg::IDX_W;
    localparam int CW = qbs_pkg::CNT_W;
    localparam int VW = qbs_pkg::VAL_W;
    localparam int SW = 2 * qbs_pkg::IDX_W;

    // sequencer codes
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PIV_RD = 4'd1;
    localparam logic [3:0] S_PIV_WT = 4'd2;
    localparam logic [3:0] S_ISTART = 4'd3;
    localparam logic [3:0] S_ISCAN  = 4'd4;
    localparam logic [3:0] S_JSTART = 4'd5;
    localparam logic [3:0] S_JSCAN  = 4'd6;
    localparam logic [3:0] S_DEC    = 4'd7;
    localparam logic [3:0] S_SW1    = 4'd8;
    localparam logic [3:0] S_SW2    = 4'd9;
    localparam logic [3:0] S_FIN1   = 4'd10;
    localparam logic [3:0] S_FIN2   = 4'd11;
    localparam logic [3:0] S_PUSHL  = 4'd12;
    localparam logic [3:0] S_POP    = 4'd13;
    localparam logic [3:0] S_POP_WT = 4'd14;
    localparam logic [3:0] S_OUT    = 4'd15;

    // element store and range stack, both with registered read data
    logic signed [VW-1:0] r_elem_mem [qbs_pkg::DEPTH];
    logic        [SW-1:0] r_stack_mem [qbs_pkg::DEPTH];
    logic signed [VW-1:0] r_elem_rd;
    logic        [SW-1:0] r_stk_rd;

    logic [3:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_ovf, n_ovf;
    logic [IW-1:0]        r_lo, n_lo;
    logic [IW-1:0]        r_hi, n_hi;
    logic [IW-1:0]        r_i, n_i;
    logic [IW-1:0]        r_j, n_j;
    logic [IW-1:0]        r_k, n_k;
    logic [CW-1:0]        r_top, n_top;
    logic signed [VW-1:0] r_pivot, n_pivot;
    logic signed [VW-1:0] r_vi, n_vi;
    logic signed [VW-1:0] r_vj, n_vj;
    logic                 r_strobe, n_strobe;
    logic                 r_res_last, n_res_last;
    logic                 r_res_trunc, n_res_trunc;

    logic                 elem_we;
    logic [IW-1:0]        elem_waddr;
    logic signed [VW-1:0] elem_wdata;
    logic [IW-1:0]        elem_raddr;
    logic                 stk_we;
    logic [IW-1:0]        stk_waddr;
    logic [SW-1:0]        stk_wdata;
    logic [IW-1:0]        stk_raddr;
    logic                 accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    function automatic logic [IW-1:0] v_inext_j(input logic [IW-1:0] idx);
        return idx + IW'(1);
    endfunction

    always_comb begin
        logic [CW-1:0] v_cnt_m1;
        logic [IW-1:0] v_inext;
        logic [IW-1:0] v_jprev;
        logic          v_out_last;

        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_top       = r_top;
        n_pivot     = r_pivot;
        n_vi        = r_vi;
        n_vj        = r_vj;
        n_strobe    = 1'b0;
        n_res_last  = r_res_last;
        n_res_trunc = r_res_trunc;

        elem_we    = 1'b0;
        elem_waddr = r_i;
        elem_wdata = r_vj;
        elem_raddr = r_k;
        stk_we     = 1'b0;
        stk_waddr  = r_top[IW-1:0];
        stk_wdata  = {r_lo, r_hi};
        stk_raddr  = r_top[IW-1:0];

        v_inext    = r_i + IW'(1);
        v_jprev    = r_j - IW'(1);
        v_cnt_m1   = r_count - CW'(1);
        v_out_last = ({1'b0, r_k} == v_cnt_m1);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // store while room is left, else drop and flag the batch
                    if (r_count < CW'(qbs_pkg::DEPTH)) begin
                        elem_we    = 1'b1;
                        elem_waddr = r_count[IW-1:0];
                        elem_wdata = i_item.value;
                        n_count    = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_item.last) begin
                        n_k   = '0;
                        n_top = '0;
                        n_lo  = '0;
                        n_hi  = IW'(n_count - CW'(1));
                        if (n_count < CW'(2)) begin
                            n_state = S_OUT;
                        end else begin
                            n_state = S_PIV_RD;
                        end
                    end
                end
            end
            S_PIV_RD: begin
                elem_raddr = r_lo;
                n_state    = S_PIV_WT;
            end
            S_PIV_WT: begin
                n_pivot = r_elem_rd;
                n_i     = r_lo;
                n_j     = r_hi;
                n_state = S_ISTART;
            end
            S_ISTART: begin
                if (r_i < r_hi) begin
                    elem_raddr = r_i;
                    n_state    = S_ISCAN;
                end else begin
                    n_state = S_JSTART;
                end
            end
            S_ISCAN: begin
                // advance over elements not above the pivot, one per cycle
                if (r_elem_rd <= r_pivot) begin
                    n_i = v_inext;
                    if (v_inext < r_hi) begin
                        elem_raddr = v_inext;
                    end else begin
                        n_state = S_JSTART;
                    end
                end else begin
                    n_vi    = r_elem_rd;
                    n_state = S_JSTART;
                end
            end
            S_JSTART: begin
                if (r_j > r_lo) begin
                    elem_raddr = r_j;
                    n_state    = S_JSCAN;
                end else begin
                    n_state = S_DEC;
                end
            end
            S_JSCAN: begin
                // retreat over elements above the pivot
                if (r_elem_rd > r_pivot) begin
                    n_j = v_jprev;
                    if (v_jprev > r_lo) begin
                        elem_raddr = v_jprev;
                    end else begin
                        n_state = S_DEC;
                    end
                end else begin
                    n_vj    = r_elem_rd;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = (r_i < r_j) ? S_SW1 : S_FIN1;
            end
            S_SW1: begin
                elem_we    = 1'b1;
                elem_waddr = r_i;
                elem_wdata = r_vj;
                n_state    = S_SW2;
            end
            S_SW2: begin
                elem_we    = 1'b1;
                elem_waddr = r_j;
                elem_wdata = r_vi;
                n_state    = S_ISTART;
            end
            S_FIN1: begin
                // pivot still sits at lo; swap it with the element at j
                elem_we    = 1'b1;
                elem_waddr = r_lo;
                elem_wdata = r_vj;
                n_state    = S_FIN2;
            end
            S_FIN2: begin
                elem_we    = 1'b1;
                elem_waddr = r_j;
                elem_wdata = r_pivot;
                if ((CW'(r_j) + CW'(1) < CW'(r_hi)) && (r_top < CW'(qbs_pkg::DEPTH))) begin
                    stk_we    = 1'b1;
                    stk_waddr = r_top[IW-1:0];
                    stk_wdata = {v_inext_j(r_j), r_hi};
                    n_top     = r_top + CW'(1);
                end
                n_state = S_PUSHL;
            end
            S_PUSHL: begin
                if ((CW'(r_lo) + CW'(1) < CW'(r_j)) && (r_top < CW'(qbs_pkg::DEPTH))) begin
                    stk_we    = 1'b1;
                    stk_waddr = r_top[IW-1:0];
                    stk_wdata = {r_lo, v_jprev};
                    n_top     = r_top + CW'(1);
                end
                n_state = S_POP;
            end
            S_POP: begin
                if (r_top != '0) begin
                    stk_raddr = IW'(r_top - CW'(1));
                    n_top     = r_top - CW'(1);
                    n_state   = S_POP_WT;
                end else begin
                    n_k     = '0;
                    n_state = S_OUT;
                end
            end
            S_POP_WT: begin
                n_lo    = r_stk_rd[SW-1:IW];
                n_hi    = r_stk_rd[IW-1:0];
                n_state = S_PIV_RD;
            end
            S_OUT: begin
                // read one sorted element a cycle; it shows on the port next cycle
                elem_raddr  = r_k;
                n_strobe    = 1'b1;
                n_res_last  = v_out_last;
                n_res_trunc = r_ovf;
                if (v_out_last) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_k = r_k + IW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (elem_we) begin
            r_elem_mem[elem_waddr] <= elem_wdata;
        end
        r_elem_rd <= r_elem_mem[elem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack_mem[stk_waddr] <= stk_wdata;
        end
        r_stk_rd <= r_stack_mem[stk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_top    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_top    <= n_top;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_i         <= n_i;
        r_j         <= n_j;
        r_k         <= n_k;
        r_pivot     <= n_pivot;
        r_vi        <= n_vi;
        r_vj        <= n_vj;
        r_res_last  <= n_res_last;
        r_res_trunc <= n_res_trunc;
    end

    assign o_strobe           = r_strobe;
    assign o_result.value_res = r_elem_rd;
    assign o_result.last_res  = r_res_last;
    assign o_result.truncated = r_res_trunc;

    `QBS_ASSERT(a_scan_in_range, (r_state == S_ISCAN) |-> (r_i < r_hi), "scan index past range")
    `QBS_ASSERT(a_stack_bound, r_top <= CW'(qbs_pkg::STACK_MAX), "range stack too deep")
    `QBS_ASSERT(a_busy_after_last, (start && !busy && i_item.last) |=> busy, "sort did not start")
    `QBS_ASSERT(a_strobe_from_out, o_strobe |-> ($past(r_state) == S_OUT), "stray result strobe")
    `QBS_ASSERT_ALWAYS(a_gap_after_last, (o_strobe && o_result.last_res) |=> !o_strobe, "result after last")

endmodule
